>>> rtl/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
package rwhp_pkg;

    // Magic and chunk tags, little-endian as assembled from the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int MAGIC_END  = 12;  // bytes taken by RIFF, size and WAVE
    localparam int FMT_MIN    = 16;  // fmt body bytes that carry the six fields
    localparam int CHUNK_HDR  = 8;   // tag plus length
    localparam int WORD_BYTES = MAGIC_END / 3;

    // Parser phases
    typedef enum logic [2:0] {
        PH_RIFF  = 3'd0,
        PH_RSIZE = 3'd1,
        PH_WAVE  = 3'd2,
        PH_HDR   = 3'd3,
        PH_BODY  = 3'd4,
        PH_PAD   = 3'd5,
        PH_HALT  = 3'd6
    } t_phase;

    // Input beat
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic        header_valid;
        logic [31:0] riff_size;
        logic [31:0] fmt_size;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] avg_byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
    } t_out_beat;

endpackage

>>> rtl/rwhp_in_reg.sv
// Input register stage: holds one byte beat until the parser takes it.
module rwhp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rwhp_pkg::t_in_beat i_in_beat,
    output logic              o_in_stall,
    input  logic              i_take,
    output logic              o_beat_valid,
    output rwhp_pkg::t_in_beat o_beat
);

    logic               r_valid;
    rwhp_pkg::t_in_beat r_beat;

    // Hold while the parser cannot take the stored beat
    assign o_in_stall   = r_valid && !i_take;
    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_beat <= i_in_beat;
        end
    end

endmodule

>>> rtl/rwhp_parse.sv
// Byte-wise parse state, chunk commit logic and result formation.
module rwhp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat_valid,
    input  rwhp_pkg::t_in_beat i_beat,
    input  logic               i_out_blocked,
    output logic               o_take,
    output logic               o_res_valid,
    output rwhp_pkg::t_out_beat o_res
);

    localparam logic [3:0] MAGIC_LAST = 4'(rwhp_pkg::WORD_BYTES - 1);
    localparam logic [3:0] HDR_LAST   = 4'(rwhp_pkg::CHUNK_HDR - 1);
    localparam logic [3:0] TAG_BYTES  = 4'(rwhp_pkg::WORD_BYTES);

    rwhp_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_hdr_cnt, n_hdr_cnt;
    logic [31:0]      r_tag, n_tag;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_body_rem, n_body_rem;
    logic [4:0]       r_body_pos, n_body_pos;
    logic [127:0]     r_pending, n_pending;
    logic             r_magic_failed, n_magic_failed;
    logic [31:0]      r_riff_size, n_riff_size;
    logic [31:0]      r_fmt_size, n_fmt_size;
    logic [127:0]     r_fmt_fields, n_fmt_fields;
    logic [31:0]      r_data_size, n_data_size;

    logic [7:0]  b;
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [31:0] rem_dec;
    logic        do_commit;
    logic        report;

    // A final byte waits while the result register is full and stalled
    assign o_take      = i_beat_valid && !(i_beat.last_byte && i_out_blocked);
    assign o_res_valid = o_take && i_beat.last_byte;

    assign b         = i_beat.byte_in;
    assign tag_shift = {b, r_tag[31:8]};
    assign len_shift = {b, r_len[31:8]};
    assign rem_dec   = r_body_rem - 32'd1;

    // Next state
    always_comb begin
        n_phase        = r_phase;
        n_hdr_cnt      = r_hdr_cnt;
        n_tag          = r_tag;
        n_len          = r_len;
        n_body_rem     = r_body_rem;
        n_body_pos     = r_body_pos;
        n_pending      = r_pending;
        n_magic_failed = r_magic_failed;
        n_riff_size    = r_riff_size;
        n_fmt_size     = r_fmt_size;
        n_fmt_fields   = r_fmt_fields;
        n_data_size    = r_data_size;
        do_commit      = 1'b0;

        if (o_take) begin
            unique case (r_phase)
                rwhp_pkg::PH_RIFF, rwhp_pkg::PH_WAVE: begin
                    n_tag     = tag_shift;
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (r_hdr_cnt == MAGIC_LAST) begin
                        n_hdr_cnt = 4'd0;
                        if (r_phase == rwhp_pkg::PH_RIFF) begin
                            if (tag_shift != rwhp_pkg::TAG_RIFF) begin
                                n_magic_failed = 1'b1;
                            end
                            n_phase = rwhp_pkg::PH_RSIZE;
                        end else if (tag_shift != rwhp_pkg::TAG_WAVE || r_magic_failed) begin
                            n_phase = rwhp_pkg::PH_HALT;
                        end else begin
                            n_phase = rwhp_pkg::PH_HDR;
                        end
                    end
                end
                rwhp_pkg::PH_RSIZE: begin
                    n_len     = len_shift;
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (r_hdr_cnt == MAGIC_LAST) begin
                        n_hdr_cnt   = 4'd0;
                        n_riff_size = len_shift;
                        n_phase     = rwhp_pkg::PH_WAVE;
                    end
                end
                rwhp_pkg::PH_HDR: begin
                    if (r_hdr_cnt < TAG_BYTES) begin
                        n_tag = tag_shift;
                    end else begin
                        n_len = len_shift;
                    end
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (r_hdr_cnt == HDR_LAST) begin
                        n_hdr_cnt  = 4'd0;
                        n_body_rem = n_len;
                        n_body_pos = 5'd0;
                        if (n_len == 32'd0) begin
                            // empty chunk commits at once
                            do_commit = 1'b1;
                        end else begin
                            n_phase = rwhp_pkg::PH_BODY;
                        end
                    end
                end
                rwhp_pkg::PH_BODY: begin
                    if (r_body_pos < 5'(rwhp_pkg::FMT_MIN)) begin
                        n_pending[{r_body_pos[3:0], 3'b000} +: 8] = b;
                        n_body_pos = r_body_pos + 5'd1;
                    end
                    n_body_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        do_commit = 1'b1;
                        n_phase   = r_len[0] ? rwhp_pkg::PH_PAD : rwhp_pkg::PH_HDR;
                    end
                end
                rwhp_pkg::PH_PAD: begin
                    n_phase = rwhp_pkg::PH_HDR;
                end
                default: begin
                end
            endcase
        end

        // Commit the finished chunk's captures
        if (do_commit) begin
            if (n_tag == rwhp_pkg::TAG_FMT) begin
                n_fmt_size = n_len;
                if (n_len >= 32'(rwhp_pkg::FMT_MIN)) begin
                    n_fmt_fields = n_pending;
                end
            end else if (n_tag == rwhp_pkg::TAG_DATA) begin
                n_data_size = n_len;
            end
        end
    end

    // Result: fields are little-endian halves and words of the fmt body
    always_comb begin
        report = (n_phase != rwhp_pkg::PH_RIFF) && (n_phase != rwhp_pkg::PH_RSIZE) &&
                 (n_phase != rwhp_pkg::PH_WAVE) && !n_magic_failed;
        o_res = '0;
        if (report) begin
            o_res.header_valid  = (n_fmt_size != 32'd0);
            o_res.riff_size     = n_riff_size;
            o_res.fmt_size      = n_fmt_size;
            o_res.format_tag    = n_fmt_fields[15:0];
            o_res.channel_count = n_fmt_fields[31:16];
            o_res.sample_rate   = n_fmt_fields[63:32];
            o_res.avg_byte_rate = n_fmt_fields[95:64];
            o_res.block_align   = n_fmt_fields[111:96];
            o_res.sample_bits   = n_fmt_fields[127:112];
            o_res.data_size     = n_data_size;
        end
    end

    // State registers; the final byte returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_phase        <= rwhp_pkg::PH_RIFF;
            r_hdr_cnt      <= 4'd0;
            r_tag          <= '0;
            r_len          <= '0;
            r_body_rem     <= '0;
            r_body_pos     <= '0;
            r_magic_failed <= 1'b0;
            r_riff_size    <= '0;
            r_fmt_size     <= '0;
            r_fmt_fields   <= '0;
            r_data_size    <= '0;
        end else begin
            r_phase        <= n_phase;
            r_hdr_cnt      <= n_hdr_cnt;
            r_tag          <= n_tag;
            r_len          <= n_len;
            r_body_rem     <= n_body_rem;
            r_body_pos     <= n_body_pos;
            r_magic_failed <= n_magic_failed;
            r_riff_size    <= n_riff_size;
            r_fmt_size     <= n_fmt_size;
            r_fmt_fields   <= n_fmt_fields;
            r_data_size    <= n_data_size;
        end
    end

    // Body capture buffer, only read after all its bytes are written
    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
    end

endmodule

>>> rtl/rwhp_out_reg.sv
// Result register: holds one result beat until the consumer takes it.
module rwhp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  rwhp_pkg::t_out_beat i_res,
    output logic                o_blocked,
    output logic                o_out_valid,
    output rwhp_pkg::t_out_beat o_out_beat,
    input  logic                i_out_stall
);

    logic                r_valid;
    rwhp_pkg::t_out_beat r_beat;

    // Full and not draining this cycle
    assign o_blocked   = r_valid && i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_beat <= i_res;
        end
    end

endmodule

>>> rtl/riff_wave_header_parser_unit.sv
// Top level of the RIFF/WAVE header parser.
//
//   channel | direction | handshake                  | beat
//   --------+-----------+----------------------------+---------------------
//   in      | input     | i_in_valid / o_in_stall    | rwhp_pkg::t_in_beat
//   out     | output    | o_out_valid / i_out_stall  | rwhp_pkg::t_out_beat
//
// One byte beat is taken per cycle unless a final byte is held back; each is parsed
// in one pass between the input register and the result register, so the result of
// a final byte passes through the input register and then the result register.
// Reset (synchronous, active low) empties both registers and puts the parser
// in the RIFF magic phase; no clearing pass is needed.
// Non-final bytes keep flowing while a result waits; only a final byte is
// held back while the result register is full and stalled.
module riff_wave_header_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rwhp_pkg::t_in_beat  i_in_beat,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output rwhp_pkg::t_out_beat o_out_beat,
    input  logic                i_out_stall
);

    logic                take;
    logic                beat_valid;
    rwhp_pkg::t_in_beat  beat;
    logic                out_blocked;
    logic                res_valid;
    rwhp_pkg::t_out_beat res;

    rwhp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_beat    (i_in_beat),
        .o_in_stall   (o_in_stall),
        .i_take       (take),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    rwhp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat_valid  (beat_valid),
        .i_beat        (beat),
        .i_out_blocked (out_blocked),
        .o_take        (take),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    rwhp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_blocked   (out_blocked),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> tb/sv/rwhp_result_checker.sv
`timescale 1ns / 100ps
// Header-result checker for the RIFF/WAVE parser: byte-level predictor plus scoreboard.
module rwhp_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rwhp_pkg::t_in_beat  i_in_beat,
    input  logic                i_in_stall,
    input  logic                i_out_valid,
    input  rwhp_pkg::t_out_beat i_out_beat,
    input  logic                i_out_stall,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen
);

    // Predicted parser state
    rwhp_pkg::t_phase wav_phase;
    logic [3:0]  hdr_count;
    logic [31:0] tag_word;
    logic [31:0] len_word;
    logic [31:0] body_left;
    logic [4:0]  body_idx;
    logic [7:0]  fmt_bytes [16];
    logic        riff_bad;

    // Committed header fields
    logic [31:0] riff_size_c;
    logic [31:0] fmt_size_c;
    logic [15:0] format_tag_c;
    logic [15:0] channels_c;
    logic [31:0] rate_c;
    logic [31:0] byte_rate_c;
    logic [15:0] align_c;
    logic [15:0] bits_c;
    logic [31:0] data_size_c;

    // Headers predicted but not yet seen on the output
    rwhp_pkg::t_out_beat header_q [$];

    int fail_count   = 0;
    int pending_cnt  = 0;
    int results_seen = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_cnt;
    assign o_results_seen = results_seen;

    task automatic clear_parser();
        wav_phase    = rwhp_pkg::PH_RIFF;
        hdr_count    = '0;
        tag_word     = '0;
        len_word     = '0;
        body_left    = '0;
        body_idx     = '0;
        riff_bad     = 1'b0;
        riff_size_c  = '0;
        fmt_size_c   = '0;
        format_tag_c = '0;
        channels_c   = '0;
        rate_c       = '0;
        byte_rate_c  = '0;
        align_c      = '0;
        bits_c       = '0;
        data_size_c  = '0;
        for (int k = 0; k < 16; k++) fmt_bytes[k] = '0;
    endtask

    // A chunk whose body is complete updates the committed fields
    task automatic commit_chunk_fields();
        if (tag_word == rwhp_pkg::TAG_FMT) begin
            fmt_size_c = len_word;
            if (len_word >= 32'(rwhp_pkg::FMT_MIN)) begin
                format_tag_c = {fmt_bytes[1], fmt_bytes[0]};
                channels_c   = {fmt_bytes[3], fmt_bytes[2]};
                rate_c       = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
                byte_rate_c  = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
                align_c      = {fmt_bytes[13], fmt_bytes[12]};
                bits_c       = {fmt_bytes[15], fmt_bytes[14]};
            end
        end else if (tag_word == rwhp_pkg::TAG_DATA) begin
            data_size_c = len_word;
        end
    endtask

    // Advance the predicted parser by one byte; a final byte yields a header
    task automatic parse_byte(input logic [7:0] b, input logic last);
        rwhp_pkg::t_out_beat res;
        case (wav_phase)
            rwhp_pkg::PH_RIFF, rwhp_pkg::PH_WAVE: begin
                tag_word  = {b, tag_word[31:8]};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= 4'(rwhp_pkg::WORD_BYTES)) begin
                    hdr_count = '0;
                    if (wav_phase == rwhp_pkg::PH_RIFF) begin
                        if (tag_word != rwhp_pkg::TAG_RIFF) riff_bad = 1'b1;
                        wav_phase = rwhp_pkg::PH_RSIZE;
                    end else begin
                        wav_phase = (tag_word != rwhp_pkg::TAG_WAVE || riff_bad) ?
                                    rwhp_pkg::PH_HALT : rwhp_pkg::PH_HDR;
                    end
                end
            end
            rwhp_pkg::PH_RSIZE: begin
                len_word  = {b, len_word[31:8]};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= 4'(rwhp_pkg::WORD_BYTES)) begin
                    hdr_count   = '0;
                    riff_size_c = len_word;
                    wav_phase   = rwhp_pkg::PH_WAVE;
                end
            end
            rwhp_pkg::PH_HDR: begin
                if (hdr_count < 4'(rwhp_pkg::WORD_BYTES)) tag_word = {b, tag_word[31:8]};
                else                                      len_word = {b, len_word[31:8]};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= 4'(rwhp_pkg::CHUNK_HDR)) begin
                    hdr_count = '0;
                    body_left = len_word;
                    body_idx  = '0;
                    // empty chunk commits right away
                    if (len_word == 32'd0) commit_chunk_fields();
                    else                   wav_phase = rwhp_pkg::PH_BODY;
                end
            end
            rwhp_pkg::PH_BODY: begin
                if (body_idx < 5'(rwhp_pkg::FMT_MIN)) begin
                    fmt_bytes[body_idx[3:0]] = b;
                    body_idx = body_idx + 5'd1;
                end
                body_left = body_left - 32'd1;
                if (body_left == 32'd0) begin
                    commit_chunk_fields();
                    wav_phase = len_word[0] ? rwhp_pkg::PH_PAD : rwhp_pkg::PH_HDR;
                end
            end
            rwhp_pkg::PH_PAD: wav_phase = rwhp_pkg::PH_HDR;
            default: ;
        endcase

        if (last) begin
            res = '0;
            if (wav_phase > rwhp_pkg::PH_WAVE && !riff_bad) begin
                res.header_valid  = (fmt_size_c != 32'd0);
                res.riff_size     = riff_size_c;
                res.fmt_size      = fmt_size_c;
                res.format_tag    = format_tag_c;
                res.channel_count = channels_c;
                res.sample_rate   = rate_c;
                res.avg_byte_rate = byte_rate_c;
                res.block_align   = align_c;
                res.sample_bits   = bits_c;
                res.data_size     = data_size_c;
            end
            header_q.push_back(res);
            clear_parser();
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    task automatic check_header(input rwhp_pkg::t_out_beat got);
        rwhp_pkg::t_out_beat want;
        if (header_q.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected header beat, expected none, actual %h", $time, got);
        end else begin
            want = header_q.pop_front();
            results_seen++;
            check_field("header_valid", 32'(want.header_valid), 32'(got.header_valid));
            check_field("riff_size", want.riff_size, got.riff_size);
            check_field("fmt_size", want.fmt_size, got.fmt_size);
            check_field("format_tag", 32'(want.format_tag), 32'(got.format_tag));
            check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
            check_field("sample_rate", want.sample_rate, got.sample_rate);
            check_field("avg_byte_rate", want.avg_byte_rate, got.avg_byte_rate);
            check_field("block_align", 32'(want.block_align), 32'(got.block_align));
            check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
            check_field("data_size", want.data_size, got.data_size);
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            header_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) parse_byte(i_in_beat.byte_in, i_in_beat.last_byte);
            if (i_out_valid && !i_out_stall) check_header(i_out_beat);
        end
        pending_cnt = header_q.size();
    end

endmodule

>>> tb/sv/riff_wave_header_parser_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the RIFF/WAVE header parser: file stimulus, idling and verdict.
module riff_wave_header_parser_unit_tb;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    rwhp_pkg::t_in_beat  in_beat   = '0;
    logic                in_stall;
    logic                out_valid;
    rwhp_pkg::t_out_beat out_beat;
    logic                out_stall = 1'b0;

    int fail_count;
    int pending;
    int results_seen;

    int tx_idle_pct  = 26;
    int rx_idle_pct  = 77;
    bit hold_off_req = 1'b0;
    int bytes_sent   = 0;
    int files_sent   = 0;
    int random_start = 0;

    logic [7:0] file_bytes [$];

    riff_wave_header_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_out_stall (out_stall)
    );

    rwhp_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_beat      (in_beat),
        .i_in_stall     (in_stall),
        .i_out_valid    (out_valid),
        .i_out_beat     (out_beat),
        .i_out_stall    (out_stall),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout: headers still outstanding = %0d", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stall, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
    endtask

    task automatic put_body(input int n);
        for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    // One byte beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        rwhp_pkg::t_in_beat beat;
        beat.byte_in   = b;
        beat.last_byte = last;
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        files_sent++;
        file_bytes.delete();
    endtask

    // Chunk tag and length, weighted toward fmt and data chunks
    task automatic pick_chunk(output logic [31:0] tag, output logic [31:0] len);
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            tag = rwhp_pkg::TAG_FMT;
            r   = $urandom_range(99);
            if (r < 55)      len = rwhp_pkg::FMT_MIN;
            else if (r < 70) len = $urandom_range(17, 24);
            else if (r < 85) len = $urandom_range(1, 15);
            else             len = 0;
        end else if (r < 70) begin
            tag = rwhp_pkg::TAG_DATA;
            len = $urandom_range(0, 21);
        end else begin
            tag = $urandom();
            len = $urandom_range(0, 9);
        end
    endtask

    // Mostly well-formed files with random content; the rest broken or short
    task automatic build_random_file();
        int          kind;
        int          nchunks;
        int          pick;
        int          lim;
        int          drop;
        logic [31:0] tag;
        logic [31:0] len;
        kind = $urandom_range(99);
        if (kind < 70) begin
            put_word(rwhp_pkg::TAG_RIFF);
            put_word($urandom());
            put_word(rwhp_pkg::TAG_WAVE);
            nchunks = $urandom_range(3);
            for (int c = 0; c < nchunks; c++) begin
                pick_chunk(tag, len);
                put_word(tag);
                put_word(len);
                put_body(len);
                if (len[0]) put_body(1);
            end
            pick = $urandom_range(99);
            if (pick >= 40 && pick < 60) begin
                // trailing partial header
                put_body($urandom_range(1, rwhp_pkg::CHUNK_HDR - 1));
            end else if (pick >= 60) begin
                // chunk cut off by the final byte
                pick_chunk(tag, len);
                if ($urandom_range(3) == 0) len = $urandom();
                lim = rwhp_pkg::CHUNK_HDR + ((len > 30) ? 30 : int'(len));
                put_word(tag);
                put_word(len);
                put_body(lim - rwhp_pkg::CHUNK_HDR);
                drop = $urandom_range(1, lim - 1);
                repeat (drop) void'(file_bytes.pop_back());
            end
        end else if (kind < 80) begin
            // WAVE magic wrong, rest ignored
            put_word(rwhp_pkg::TAG_RIFF);
            put_word($urandom());
            if ($urandom_range(1)) put_word(rwhp_pkg::TAG_WAVE ^ (32'h1 << $urandom_range(31)));
            else                   put_word($urandom());
            put_word(rwhp_pkg::TAG_FMT);
            put_word(rwhp_pkg::FMT_MIN);
            put_body(rwhp_pkg::FMT_MIN);
        end else if (kind < 90) begin
            // RIFF magic wrong
            put_word(rwhp_pkg::TAG_RIFF ^ (32'h1 << $urandom_range(31)));
            put_word($urandom());
            put_word(rwhp_pkg::TAG_WAVE);
            put_word(rwhp_pkg::TAG_FMT);
            put_word(rwhp_pkg::FMT_MIN);
            put_body(rwhp_pkg::FMT_MIN);
        end else begin
            // stream ends inside the magics
            put_word(rwhp_pkg::TAG_RIFF);
            put_word($urandom());
            put_word(rwhp_pkg::TAG_WAVE);
            pick = $urandom_range(1, rwhp_pkg::MAGIC_END - 1);
            while (file_bytes.size() > pick) void'(file_bytes.pop_back());
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte stream, bare header with all-ones size, bad RIFF
        file_bytes.push_back(8'h00);
        send_file();
        put_word(rwhp_pkg::TAG_RIFF);
        put_word(32'hFFFF_FFFF);
        put_word(rwhp_pkg::TAG_WAVE);
        send_file();
        put_word(rwhp_pkg::TAG_RIFF ^ 32'h8000_0000);
        put_word(32'h0000_0000);
        put_word(rwhp_pkg::TAG_WAVE);
        send_file();

        // Receiver holds off while one-byte files keep coming
        tx_idle_pct  = 0;
        hold_off_req = 1'b1;
        repeat (5) begin
            file_bytes.push_back(8'($urandom_range(255)));
            send_file();
        end

        // Random files across three idle profiles
        random_start = bytes_sent;
        while (bytes_sent - random_start < 1750 || files_sent < 56) begin
            if (bytes_sent - random_start < 583) begin
                tx_idle_pct = 26;
                rx_idle_pct = 77;
            end else if (bytes_sent - random_start < 1166) begin
                tx_idle_pct = 77;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            build_random_file();
            send_file();
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        // Drain, then keep watching for stray beats
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Streamed %0d files in %0d byte beats, incl. a long output hold-off.",
                 files_sent, bytes_sent);
        $display("Compared %0d header results under three idle profiles, %0d errors.",
                 results_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
